// ===== rtl/srgbok_pkg.sv =====
// Shared types, constants and the sRGB linearization table for the sRGB to OKLCH converter.
package srgbok_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_ENTRIES      = 24;

	localparam int LIN_W      = 25;
	localparam int VAL_W      = 29;
	localparam int COEF_W     = 36;
	localparam int CBRT_BITS  = 25;
	localparam int SQRT_CELLS = 26;
	localparam int ROOT_W     = SQRT_CELLS;
	localparam int RAD_W      = 2 * SQRT_CELLS;
	localparam int REM_W      = SQRT_CELLS + 3;
	localparam int XY_W       = 28;
	localparam int ANG_W      = 32;
	localparam int ROW_LAT    = 5;
	localparam int MAG_W      = 62;
	localparam int QUO_W      = 28;
	localparam int RECIP_SH   = 62;
	localparam int PIX_W      = 8;

	localparam longint unsigned Q24_ONE   = 64'd16777216;
	localparam longint unsigned COEF_DEN  = 64'd10000000000;
	localparam longint unsigned COEF_HALF = COEF_DEN / 2;
	localparam longint unsigned RECIP     = (64'd1 << RECIP_SH) / COEF_DEN;

	localparam logic signed [ANG_W-1:0] ANG_180 = 32'sd754974720;
	localparam logic signed [ANG_W-1:0] ANG_360 = 32'sd1509949440;
	localparam logic [15:0] HUE_FULL = 16'd23040;

	typedef logic signed [VAL_W-1:0]  val_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef coef_t coef_row_t [3];
	typedef coef_row_t mat_t [3];
	typedef logic [LIN_W-1:0] lin_tab_t [256];
	typedef logic signed [ANG_W-1:0] atan_tab_t [ATAN_ENTRIES];

	localparam mat_t MAT_LMS = '{
		'{36'sd4122214708, 36'sd5363325363, 36'sd514459929},
		'{36'sd2119034982, 36'sd6806995451, 36'sd1073969566},
		'{36'sd883024619,  36'sd2817188376, 36'sd6299787005}
	};

	localparam mat_t MAT_LAB = '{
		'{36'sd2104542553,  36'sd7936177850,  -36'sd40720468},
		'{36'sd19779984951, -36'sd24285922050, 36'sd4505937099},
		'{36'sd259040371,   36'sd7827717662,  -36'sd8086757660}
	};

	localparam atan_tab_t ATAN_TAB = '{
		32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
		32'sd15000234, 32'sd7507429, 32'sd3754631, 32'sd1877430,
		32'sd938729, 32'sd469366, 32'sd234683, 32'sd117342,
		32'sd58671, 32'sd29335, 32'sd14668, 32'sd7334,
		32'sd3667, 32'sd1833, 32'sd917, 32'sd458,
		32'sd229, 32'sd115, 32'sd57, 32'sd29
	};

	function automatic logic [LIN_W-1:0] lin_of(input int unsigned v);
		longint unsigned vv, t, t2, lo, hi, mid, p2, p4, p5;
		vv = 64'(v);
		if (vv <= 64'd10) begin
			return LIN_W'((vv * 64'd10 * Q24_ONE + 64'd16473) / 64'd32946);
		end
		t  = (((64'd1000 * vv + 64'd14025) << 24) + 64'd134512) / 64'd269025;
		t2 = (t * t + (64'd1 << 23)) >> 24;
		lo = 64'd0;
		hi = Q24_ONE;
		while (lo < hi) begin
			mid = (lo + hi + 64'd1) >> 1;
			p2  = (mid * mid) >> 24;
			p4  = (p2 * p2) >> 24;
			p5  = (p4 * mid) >> 24;
			if (p5 <= t2) begin
				lo = mid;
			end else begin
				hi = mid - 64'd1;
			end
		end
		return LIN_W'((t2 * lo + (64'd1 << 23)) >> 24);
	endfunction

	function automatic lin_tab_t lin_tab_build();
		lin_tab_t tab;
		for (int i = 0; i < 256; i++) begin
			tab[i] = lin_of(i);
		end
		return tab;
	endfunction

	localparam lin_tab_t LIN_TAB = lin_tab_build();

endpackage

// ===== rtl/srgb_to_oklch_converter.sv =====
// Top level of the sRGB to OKLCH pixel converter.
//
//  channel | dir | handshake         | word
//  s_*     | in  | s_tvalid/s_tready | red, green, blue (8 bits each)
//  m_*     | out | m_tvalid/m_tready | lightness, chroma (16 bits), hue (15 bits)
//
// One pixel per cycle unless the output stalls; stages: table lookup, LMS matrix (5),
// cube root chain of 25 two-stage cells, OKLab matrix (5), square root chain
// of 26 cells with squaring and output stages; the CORDIC chain runs beside it.
// Reset clears the valid bits only. A stalled output freezes the whole pipeline.
module srgb_to_oklch_converter #(
	parameter int CORDIC_STAGES = srgbok_pkg::CORDIC_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // red[7:0], green[15:8], blue[23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // lightness[15:0], chroma[31:16], hue[46:32]
);

	localparam int VW    = srgbok_pkg::VAL_W;
	localparam int CB    = srgbok_pkg::CBRT_BITS;
	localparam int SC    = srgbok_pkg::SQRT_CELLS;
	localparam int XW    = srgbok_pkg::XY_W;
	localparam int AW    = srgbok_pkg::ANG_W;
	localparam int LAT   = 1 + 2 * srgbok_pkg::ROW_LAT + 2 * CB + SC + 3;
	localparam int HUE_PAD = SC - CORDIC_STAGES;
	localparam int LZ_LEN  = SC + 2;

	typedef struct packed {
		srgbok_pkg::val_t l;
		logic             zero;
	} lz_t;

	logic           en;
	logic [LAT-1:0] vld_q;

	srgbok_pkg::val_t lin_s1 [3];
	srgbok_pkg::val_t lms [3];
	srgbok_pkg::val_t lab_in [3];
	srgbok_pkg::val_t lab [3];
	srgbok_pkg::val_t cx [3][CB+1];
	logic [CB-1:0]    cy [3][CB+1];

	lz_t lz_q [LZ_LEN];

	logic signed [25:0]           a26;
	logic signed [25:0]           b26;
	logic [srgbok_pkg::RAD_W-1:0] asq_s1;
	logic [srgbok_pkg::RAD_W-1:0] bsq_s1;
	logic [srgbok_pkg::RAD_W-1:0] rad_s2;
	logic [srgbok_pkg::RAD_W-1:0] rad_ch [SC+1];
	logic [srgbok_pkg::REM_W-1:0] rem_ch [SC+1];
	logic [srgbok_pkg::ROOT_W-1:0] root_ch [SC+1];

	logic signed [XW-1:0] hx_s1;
	logic signed [XW-1:0] hy_s1;
	logic signed [AW-1:0] hz_s1;
	logic signed [XW-1:0] hx [CORDIC_STAGES+1];
	logic signed [XW-1:0] hy [CORDIC_STAGES+1];
	logic signed [AW-1:0] hz [CORDIC_STAGES+1];
	logic signed [AW-1:0] zw;
	logic [AW-2:0]        wrap_q;
	logic [AW-2:0]        hpad_q [HUE_PAD];

	logic [28:0] lsum;
	logic [26:0] csum;
	logic [31:0] hsum;
	logic [15:0] light_q;
	logic [15:0] chroma_q;
	logic [14:0] hue_q;
	lz_t         lz_end;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];
	assign m_tdata  = {1'b0, hue_q, chroma_q, light_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				lin_s1[c] <= $signed({{(VW - srgbok_pkg::LIN_W){1'b0}},
					srgbok_pkg::LIN_TAB[s_tdata[c*srgbok_pkg::PIX_W +: srgbok_pkg::PIX_W]]});
			end
		end
	end

	genvar c, k;
	generate
		for (c = 0; c < 3; c++) begin : g_ch
			srgbok_row u_lms (
				.clk  (clk),
				.en   (en),
				.coef (srgbok_pkg::MAT_LMS[c]),
				.val  (lin_s1),
				.res  (lms[c])
			);

			assign cx[c][0] = (lms[c] <= 0) ? '1 : lms[c];
			assign cy[c][0] = '0;

			for (k = 0; k < CB; k++) begin : g_cbrt
				srgbok_cbrt_cell #(.BIT(CB - 1 - k)) u_cell (
					.clk   (clk),
					.en    (en),
					.x_in  (cx[c][k]),
					.y_in  (cy[c][k]),
					.x_out (cx[c][k+1]),
					.y_out (cy[c][k+1])
				);
			end

			assign lab_in[c] = $signed({{(VW - CB){1'b0}}, cy[c][CB]});

			srgbok_row u_lab (
				.clk  (clk),
				.en   (en),
				.coef (srgbok_pkg::MAT_LAB[c]),
				.val  (lab_in),
				.res  (lab[c])
			);
		end
	endgenerate

	assign a26 = lab[1][25:0];
	assign b26 = lab[2][25:0];

	always_ff @(posedge clk) begin
		if (en) begin
			lz_q[0] <= '{l: lab[0], zero: (lab[1] == '0) && (lab[2] == '0)};
			for (int i = 1; i < LZ_LEN; i++) begin
				lz_q[i] <= lz_q[i-1];
			end
			asq_s1 <= $unsigned(srgbok_pkg::RAD_W'(a26) * srgbok_pkg::RAD_W'(a26));
			bsq_s1 <= $unsigned(srgbok_pkg::RAD_W'(b26) * srgbok_pkg::RAD_W'(b26));
			rad_s2 <= asq_s1 + bsq_s1;
			if (a26 < 0) begin
				hx_s1 <= -XW'(a26);
				hy_s1 <= -XW'(b26);
				hz_s1 <= srgbok_pkg::ANG_180;
			end else begin
				hx_s1 <= XW'(a26);
				hy_s1 <= XW'(b26);
				hz_s1 <= '0;
			end
			wrap_q    <= zw[AW-2:0];
			hpad_q[0] <= wrap_q;
			for (int i = 1; i < HUE_PAD; i++) begin
				hpad_q[i] <= hpad_q[i-1];
			end
		end
	end

	assign rad_ch[0]  = rad_s2;
	assign rem_ch[0]  = '0;
	assign root_ch[0] = '0;
	assign hx[0]      = hx_s1;
	assign hy[0]      = hy_s1;
	assign hz[0]      = hz_s1;

	generate
		for (k = 0; k < SC; k++) begin : g_sqrt
			srgbok_sqrt_cell #(.PAIR(SC - 1 - k)) u_cell (
				.clk      (clk),
				.en       (en),
				.rad_in   (rad_ch[k]),
				.rem_in   (rem_ch[k]),
				.root_in  (root_ch[k]),
				.rad_out  (rad_ch[k+1]),
				.rem_out  (rem_ch[k+1]),
				.root_out (root_ch[k+1])
			);
		end

		for (k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
			srgbok_cordic_cell #(.IDX(k)) u_cell (
				.clk   (clk),
				.en    (en),
				.x_in  (hx[k]),
				.y_in  (hy[k]),
				.z_in  (hz[k]),
				.x_out (hx[k+1]),
				.y_out (hy[k+1]),
				.z_out (hz[k+1])
			);
		end
	endgenerate

	always_comb begin
		if (hz[CORDIC_STAGES] < 0) begin
			zw = hz[CORDIC_STAGES] + srgbok_pkg::ANG_360;
		end else if (hz[CORDIC_STAGES] >= srgbok_pkg::ANG_360) begin
			zw = hz[CORDIC_STAGES] - srgbok_pkg::ANG_360;
		end else begin
			zw = hz[CORDIC_STAGES];
		end
		lz_end = lz_q[LZ_LEN-1];
		lsum   = {1'b0, lz_end.l[27:0]} + 29'd128;
		csum   = {1'b0, root_ch[SC]} + 27'd128;
		hsum   = {1'b0, hpad_q[HUE_PAD-1]} + 32'd32768;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (lz_end.l <= 0) begin
				light_q <= '0;
			end else if (|lsum[28:24]) begin
				light_q <= '1;
			end else begin
				light_q <= lsum[23:8];
			end
			chroma_q <= (|csum[26:24]) ? '1 : csum[23:8];
			if (lz_end.zero || (hsum[31:16] >= srgbok_pkg::HUE_FULL)) begin
				hue_q <= '0;
			end else begin
				hue_q <= hsum[30:16];
			end
		end
	end

endmodule

// ===== rtl/srgbok_row.sv =====
// One matrix row: three constant products, sum, and rounded division by the coefficient scale.
module srgbok_row (
	input  logic                  clk,
	input  logic                  en,
	input  srgbok_pkg::coef_row_t coef,
	input  srgbok_pkg::val_t      val [3],
	output srgbok_pkg::val_t      res
);

	localparam int PROD_W = srgbok_pkg::COEF_W + srgbok_pkg::VAL_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int LO_W   = srgbok_pkg::MAG_W / 2;
	localparam int HI_W   = srgbok_pkg::MAG_W - LO_W;
	localparam int RCP_W  = 29;
	localparam int PP_W   = LO_W + RCP_W;
	localparam int ACC_W  = srgbok_pkg::MAG_W + RCP_W;

	localparam logic [RCP_W-1:0] RCP = RCP_W'(srgbok_pkg::RECIP);

	logic signed [PROD_W-1:0]     prod_s1 [3];
	logic [srgbok_pkg::MAG_W-1:0] mag_s2;
	logic                         neg_s2;
	logic [PP_W-1:0]              pp_lo_s3;
	logic [PP_W-1:0]              pp_hi_s3;
	logic [srgbok_pkg::MAG_W-1:0] mag_s3;
	logic                         neg_s3;
	logic [srgbok_pkg::MAG_W-1:0] mag_s4;
	logic [srgbok_pkg::QUO_W-1:0] quo_s4;
	logic                         neg_s4;
	srgbok_pkg::val_t             res_s5;

	logic signed [SUM_W-1:0]      sum;
	logic signed [SUM_W-1:0]      sum_abs;
	logic [ACC_W-1:0]             recip_prod;
	logic [srgbok_pkg::MAG_W-1:0] rem;
	logic [srgbok_pkg::VAL_W-1:0] quo_fix;

	always_comb begin
		sum        = SUM_W'(prod_s1[0]) + SUM_W'(prod_s1[1]) + SUM_W'(prod_s1[2]);
		sum_abs    = (sum < 0) ? -sum : sum;
		recip_prod = (ACC_W'(pp_hi_s3) << LO_W) + ACC_W'(pp_lo_s3);
		rem        = mag_s4 - srgbok_pkg::MAG_W'(quo_s4) *
			srgbok_pkg::MAG_W'(srgbok_pkg::COEF_DEN);
		quo_fix    = srgbok_pkg::VAL_W'(quo_s4) +
			srgbok_pkg::VAL_W'(rem >= srgbok_pkg::MAG_W'(srgbok_pkg::COEF_DEN));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= PROD_W'(coef[i]) * PROD_W'(val[i]);
			end
			neg_s2 <= (sum < 0);
			mag_s2 <= sum_abs[srgbok_pkg::MAG_W-1:0] +
				srgbok_pkg::MAG_W'(srgbok_pkg::COEF_HALF);
			neg_s3   <= neg_s2;
			mag_s3   <= mag_s2;
			pp_lo_s3 <= PP_W'(mag_s2[LO_W-1:0]) * PP_W'(RCP);
			pp_hi_s3 <= PP_W'(mag_s2[LO_W +: HI_W]) * PP_W'(RCP);
			neg_s4   <= neg_s3;
			mag_s4   <= mag_s3;
			quo_s4   <= recip_prod[srgbok_pkg::RECIP_SH +: srgbok_pkg::QUO_W];
			res_s5   <= neg_s4 ? -$signed(quo_fix) : $signed(quo_fix);
		end
	end

	assign res = res_s5;

endmodule

// ===== rtl/srgbok_cbrt_cell.sv =====
// Cube root cell: settles one result bit over two stages.
module srgbok_cbrt_cell #(
	parameter int BIT = 0
) (
	input  logic                             clk,
	input  logic                             en,
	input  srgbok_pkg::val_t                 x_in,
	input  logic [srgbok_pkg::CBRT_BITS-1:0] y_in,
	output srgbok_pkg::val_t                 x_out,
	output logic [srgbok_pkg::CBRT_BITS-1:0] y_out
);

	localparam int YW = srgbok_pkg::CBRT_BITS;

	logic [YW-1:0]    cand;
	logic [2*YW-1:0]  sq_full;
	logic [YW-1:0]    cand_s1;
	logic [YW:0]      sq_s1;
	logic [YW-1:0]    y_s1;
	srgbok_pkg::val_t x_s1;
	logic [2*YW:0]    cube_full;
	logic [YW+1:0]    cube;
	logic [YW-1:0]    y_s2;
	srgbok_pkg::val_t x_s2;

	always_comb begin
		cand      = y_in | (YW'(1) << BIT);
		sq_full   = (2*YW)'(cand) * (2*YW)'(cand);
		cube_full = (2*YW+1)'(sq_s1) * (2*YW+1)'(cand_s1);
		cube      = cube_full[2*YW:24];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cand_s1 <= cand;
			sq_s1   <= sq_full[2*YW-1:24];
			y_s1    <= y_in;
			x_s1    <= x_in;
			y_s2    <= ($signed({2'b00, cube}) <= x_s1) ? cand_s1 : y_s1;
			x_s2    <= x_s1;
		end
	end

	assign x_out = x_s2;
	assign y_out = y_s2;

endmodule

// ===== rtl/srgbok_sqrt_cell.sv =====
// Square root cell: takes two radicand bits and settles one root bit.
module srgbok_sqrt_cell #(
	parameter int PAIR = 0
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [srgbok_pkg::RAD_W-1:0]  rad_in,
	input  logic [srgbok_pkg::REM_W-1:0]  rem_in,
	input  logic [srgbok_pkg::ROOT_W-1:0] root_in,
	output logic [srgbok_pkg::RAD_W-1:0]  rad_out,
	output logic [srgbok_pkg::REM_W-1:0]  rem_out,
	output logic [srgbok_pkg::ROOT_W-1:0] root_out
);

	localparam int RW = srgbok_pkg::REM_W;
	localparam int TW = srgbok_pkg::ROOT_W;

	logic [RW-1:0] rem_sh;
	logic [RW-1:0] trial;
	logic          take;
	logic [srgbok_pkg::RAD_W-1:0] rad_q;
	logic [RW-1:0] rem_q;
	logic [TW-1:0] root_q;

	always_comb begin
		rem_sh = {rem_in[RW-3:0], rad_in[2*PAIR+1 -: 2]};
		trial  = {1'b0, root_in, 2'b01};
		take   = (rem_sh >= trial);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= rad_in;
			rem_q  <= take ? (rem_sh - trial) : rem_sh;
			root_q <= {root_in[TW-2:0], take};
		end
	end

	assign rad_out  = rad_q;
	assign rem_out  = rem_q;
	assign root_out = root_q;

endmodule

// ===== rtl/srgbok_cordic_cell.sv =====
// Vectoring CORDIC cell: one micro-rotation toward the positive x axis.
module srgbok_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [srgbok_pkg::XY_W-1:0]  x_in,
	input  logic signed [srgbok_pkg::XY_W-1:0]  y_in,
	input  logic signed [srgbok_pkg::ANG_W-1:0] z_in,
	output logic signed [srgbok_pkg::XY_W-1:0]  x_out,
	output logic signed [srgbok_pkg::XY_W-1:0]  y_out,
	output logic signed [srgbok_pkg::ANG_W-1:0] z_out
);

	logic signed [srgbok_pkg::XY_W-1:0]  xs;
	logic signed [srgbok_pkg::XY_W-1:0]  ys;
	logic signed [srgbok_pkg::XY_W-1:0]  x_q;
	logic signed [srgbok_pkg::XY_W-1:0]  y_q;
	logic signed [srgbok_pkg::ANG_W-1:0] z_q;

	assign xs = x_in >>> IDX;
	assign ys = y_in >>> IDX;

	always_ff @(posedge clk) begin
		if (en) begin
			if (y_in > 0) begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + srgbok_pkg::ATAN_TAB[IDX];
			end else begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - srgbok_pkg::ATAN_TAB[IDX];
			end
		end
	end

	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;

endmodule

// ===== sim/testbench.sv =====
// Testbench for the sRGB to OKLCH converter: directed and random pixels checked by a predictor.
`timescale 1ns / 1ps

module testbench;

	localparam int STAGES      = 16;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [14:0] hue;
		logic [15:0] chroma;
		logic [15:0] lightness;
	} oklch_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // red[7:0], green[15:8], blue[23:16]
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // lightness[15:0], chroma[31:16], hue[46:32]

	oklch_t oklch_due[$];
	int     errors;
	int     cycles;
	bit     calm;
	int     stall_left;

	srgb_to_oklch_converter #(.CORDIC_STAGES(STAGES)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned linearize(int unsigned code);
		longint unsigned v, t, t2, lo, hi, mid, p2, p4;
		v = longint'(code);
		if (v <= 10)
			return (v * 10 * 64'd16777216 + 16473) / 32946;
		t  = (((1000 * v + 14025) << 24) + 134512) / 269025;
		t2 = (t * t + (64'd1 << 23)) >> 24;
		lo = 0;
		hi = 64'd16777216;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			p2  = (mid * mid) >> 24;
			p4  = (p2 * p2) >> 24;
			if (((p4 * mid) >> 24) <= t2)
				lo = mid;
			else
				hi = mid - 1;
		end
		return (t2 * lo + (64'd1 << 23)) >> 24;
	endfunction

	function automatic longint signed round_coef(longint signed n);
		if (n >= 0)
			return (n + 64'sd5000000000) / 64'sd10000000000;
		return -((-n + 64'sd5000000000) / 64'sd10000000000);
	endfunction

	function automatic longint signed cube_root(longint signed x);
		longint unsigned lo, hi, mid;
		lo = 0;
		hi = (64'd1 << 25) - 1;
		if (x <= 0)
			return 0;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (((((mid * mid) >> 24) * mid) >> 24) <= longint'(x))
				lo = mid;
			else
				hi = mid - 1;
		end
		return longint'(lo);
	endfunction

	function automatic longint unsigned square_root(longint unsigned n);
		longint unsigned lo, hi, mid;
		lo = 0;
		hi = 64'hFFFFFFFF;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (mid * mid <= n)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic logic [15:0] q16_sat(longint signed q24);
		longint signed r;
		if (q24 <= 0)
			return 16'd0;
		r = (q24 + 128) >>> 8;
		return (r > 65535) ? 16'hFFFF : r[15:0];
	endfunction

	function automatic logic [14:0] hue_angle(longint signed a, longint signed b);
		longint signed x, y, z, xs, ys, r;
		x = a;
		y = b;
		z = 0;
		if (a == 0 && b == 0)
			return 15'd0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = longint'(srgbok_pkg::ANG_180);
		end
		for (int i = 0; i < STAGES && i < srgbok_pkg::ATAN_ENTRIES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys;
				y -= xs;
				z += longint'(srgbok_pkg::ATAN_TAB[i]);
			end else begin
				x -= ys;
				y += xs;
				z -= longint'(srgbok_pkg::ATAN_TAB[i]);
			end
		end
		while (z < 0)
			z += longint'(srgbok_pkg::ANG_360);
		while (z >= longint'(srgbok_pkg::ANG_360))
			z -= longint'(srgbok_pkg::ANG_360);
		r = (z + 32768) >>> 16;
		if (r >= 23040)
			r = 0;
		return r[14:0];
	endfunction

	function automatic oklch_t oklch_of(logic [23:0] pix);
		longint signed rgb [3];
		longint signed lms [3];
		longint signed lab [3];
		longint signed acc;
		longint unsigned csq;
		oklch_t res;
		for (int i = 0; i < 3; i++)
			rgb[i] = longint'(linearize(32'(pix[8*i +: 8])));
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++)
				acc += longint'(srgbok_pkg::MAT_LMS[i][j]) * rgb[j];
			lms[i] = cube_root(round_coef(acc));
		end
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++)
				acc += longint'(srgbok_pkg::MAT_LAB[i][j]) * lms[j];
			lab[i] = round_coef(acc);
		end
		csq = longint'(lab[1] * lab[1]) + longint'(lab[2] * lab[2]);
		res.lightness = q16_sat(lab[0]);
		res.chroma    = q16_sat(longint'(square_root(csq)));
		res.hue       = hue_angle(lab[1], lab[2]);
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		$display("bad %s", msg);
		errors++;
	endtask

	always @(posedge clk) begin
		oklch_t got, want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("srgb_to_oklch_converter: mismatch");
			$finish;
		end else begin
			if (s_tvalid && s_tready)
				oklch_due.push_back(oklch_of(s_tdata));
			if (m_tvalid && m_tready) begin
				got = m_tdata[46:0];
				if (oklch_due.size() == 0) begin
					report_mismatch($sformatf("unexpected word %h", m_tdata));
				end else begin
					want = oklch_due.pop_front();
					if (got.lightness !== want.lightness)
						report_mismatch($sformatf("lightness: got %0d, expected %0d",
							got.lightness, want.lightness));
					if (got.chroma !== want.chroma)
						report_mismatch($sformatf("chroma: got %0d, expected %0d",
							got.chroma, want.chroma));
					if (got.hue !== want.hue)
						report_mismatch($sformatf("hue: got %0d, expected %0d",
							got.hue, want.hue));
				end
			end
		end
	end

	always @(posedge clk) begin
		logic rdy;
		if (calm) begin
			rdy = 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rdy = 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = int'($urandom_range(0, 6));
			rdy = 1'b0;
		end else begin
			rdy = 1'b1;
		end
		m_tready <= rdy;
	end

	task automatic send_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {blue, green, red};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic test_directed();
		logic [7:0] corner [6] = '{8'd0, 8'd10, 8'd11, 8'd128, 8'd254, 8'd255};
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		foreach (corner[i])
			send_pixel(corner[i], corner[i], corner[i]);
		send_pixel(8'd10, 8'd11, 8'd10);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		send_pixel(8'd200, 8'd201, 8'd200);
		send_pixel(8'd170, 8'd85, 8'd85);
		send_pixel(8'd85, 8'd85, 8'd170);
	endtask

	task automatic test_random(int count);
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 3))
				0: send_pixel(8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
					8'($urandom_range(0, 12)));
				1: begin
					logic [7:0] g;
					g = 8'($urandom_range(0, 255));
					send_pixel(g, g ^ 8'($urandom_range(0, 1)), g);
				end
				default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
			endcase
		end
	endtask

	task automatic test_drain_pause();
		test_random(20);
		s_tvalid <= 1'b0;
		while (oklch_due.size() != 0)
			@(posedge clk);
		test_random(20);
	endtask

	task automatic test_streaming();
		calm = 1'b1;
		test_random(300);
	endtask

	initial begin
		calm       = 1'b0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(500);
		test_drain_pause();
		test_random(500);
		test_streaming();
		s_tvalid <= 1'b0;
		while (oklch_due.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
		if (errors == 0)
			$display("srgb_to_oklch_converter: match");
		else
			$display("srgb_to_oklch_converter: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/srgbok_pkg.sv
rtl/srgbok_row.sv
rtl/srgbok_cbrt_cell.sv
rtl/srgbok_sqrt_cell.sv
rtl/srgbok_cordic_cell.sv
rtl/srgb_to_oklch_converter.sv
sim/testbench.sv
